// File: hdl/hcs_pkg.sv
// Package for the hue color segment column peak unit.
// Holds the controller state type, register indexes, divider step count and command and status types.
// No dependencies.
package hcs_pkg;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_DIV,
    ST_OUT
  } state_e;

  localparam logic [2:0] REG_HUE_LOW      = 3'd0;
  localparam logic [2:0] REG_HUE_HIGH     = 3'd1;
  localparam logic [2:0] REG_SAT_MIN      = 3'd2;
  localparam logic [2:0] REG_LIGHT_MIN    = 3'd3;
  localparam logic [2:0] REG_FRAME_WIDTH  = 3'd4;
  localparam logic [2:0] REG_FRAME_HEIGHT = 3'd5;

  localparam int unsigned DivSteps = 16;

  typedef struct packed {
    logic load;
    logic prep;
    logic step;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic div_done;
  } status_t;

endpackage

// File: hdl/hcs_ctrl.sv
// Controller of the hue color segment column peak unit.
// Sequences load, divide and output of one item. Depends on hcs_pkg.
module hcs_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  hcs_pkg::status_t status_i,
  output hcs_pkg::cmd_t    cmd_o
);
  import hcs_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_valid_i) state_d = ST_CALC;
      ST_CALC: state_d = ST_DIV;
      ST_DIV:  if (status_i.div_done) state_d = ST_OUT;
      ST_OUT:  if (out_ready_i) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    cmd_o       = '0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_CALC: cmd_o.prep = 1'b1;
      ST_DIV:  cmd_o.step = 1'b1;
      ST_OUT: begin
        out_valid_o  = 1'b1;
        cmd_o.commit = out_ready_i;
      end
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  a_no_both: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o)) else $error("ready and valid together");
  a_load_calc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> state_q == ST_CALC) else $error("load not followed by calc");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o) else $error("result dropped");
`endif

endmodule

// File: hdl/hcs_datapath.sv
// Datapath of the hue color segment column peak unit.
// Color math, two parallel restoring dividers and frame counters. Depends on hcs_pkg.
module hcs_datapath #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 1024
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  hcs_pkg::cmd_t    cmd_i,
  output hcs_pkg::status_t status_o,
  input  logic             cfg_valid_i,
  input  logic [2:0]       cfg_index_i,
  input  logic [10:0]      cfg_data_i,
  input  logic [7:0]       red_i,
  input  logic [7:0]       green_i,
  input  logic [7:0]       blue_i,
  input  logic             start_of_frame_i,
  output logic [7:0]       out_red_o,
  output logic [7:0]       out_green_o,
  output logic [7:0]       out_blue_o,
  output logic             is_target_o,
  output logic             frame_done_o,
  output logic [9:0]       best_column_o,
  output logic [10:0]      best_column_count_o,
  output logic [20:0]      target_count_o,
  output logic             found_o
);
  import hcs_pkg::*;

  localparam int WW = $clog2(MAX_WIDTH);
  localparam int HW = $clog2(MAX_HEIGHT);

  logic [7:0]  hue_low_q, hue_high_q;
  logic [6:0]  sat_min_q, light_min_q;
  logic [10:0] width_q, height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hue_low_q   <= 8'd10;
      hue_high_q  <= 8'd80;
      sat_min_q   <= 7'd20;
      light_min_q <= 7'd20;
      width_q     <= 11'd320;
      height_q    <= 11'd240;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_HUE_LOW:      hue_low_q   <= cfg_data_i[7:0];
        REG_HUE_HIGH:     hue_high_q  <= cfg_data_i[7:0];
        REG_SAT_MIN:      sat_min_q   <= cfg_data_i[6:0];
        REG_LIGHT_MIN:    light_min_q <= cfg_data_i[6:0];
        REG_FRAME_WIDTH:  width_q     <= cfg_data_i;
        REG_FRAME_HEIGHT: height_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Pixel registers and derived values.
  logic [7:0] r_q, g_q, b_q;
  logic       sof_q;
  logic [7:0] mx, mn;
  logic [8:0] sum;
  logic [7:0] delta;
  logic       grey;
  logic [7:0] hbase;
  logic       hneg;
  logic [7:0] hdiff;
  logic [26:0] lmul;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      r_q   <= red_i;
      g_q   <= green_i;
      b_q   <= blue_i;
      sof_q <= start_of_frame_i;
    end
  end

  always_comb begin
    mx = (r_q > g_q) ? r_q : g_q;
    mx = (mx > b_q) ? mx : b_q;
    mn = (r_q < g_q) ? r_q : g_q;
    mn = (mn < b_q) ? mn : b_q;
    sum   = {1'b0, mx} + {1'b0, mn};
    delta = mx - mn;
    grey  = ({delta, 1'b0} <= {1'b0, mx});
    // Lightness is 10 * sum / 51, taken as a scaled reciprocal product.
    lmul  = 27'(sum) * 27'd205610;
    if (r_q == mx) begin
      hbase = 8'd42;
      hneg  = g_q < b_q;
      hdiff = hneg ? b_q - g_q : g_q - b_q;
    end else if (g_q == mx) begin
      hbase = 8'd126;
      hneg  = b_q < r_q;
      hdiff = hneg ? r_q - b_q : b_q - r_q;
    end else begin
      hbase = 8'd210;
      hneg  = r_q < g_q;
      hdiff = hneg ? g_q - r_q : r_q - g_q;
    end
  end

  // Two restoring divisions run side by side, one quotient bit per cycle.
  logic [15:0] hn_q, sn_q;
  logic [8:0]  hd_q, sd_q;
  logic [15:0] hq_q, sq_q;
  logic [6:0]  lq_q;
  logic [16:0] hr_q, sr_q;
  logic [4:0]  cnt_q;
  logic [7:0]  hbase_q;
  logic        hneg_q, grey_q, sz_q;
  logic [16:0] hr_t, sr_t;

  always_comb begin
    hr_t = {hr_q[15:0], hn_q[15]};
    sr_t = {sr_q[15:0], sn_q[15]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.prep) begin
      cnt_q <= 5'(DivSteps);
    end else if (cmd_i.step && cnt_q != 5'd0) begin
      cnt_q <= cnt_q - 5'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.prep) begin
      hn_q    <= 16'(hdiff) * 16'd42;
      hd_q    <= {1'b0, delta};
      sn_q    <= 16'(delta) * 16'd100;
      sd_q    <= (sum < 9'd255) ? sum : 9'd510 - sum;
      lq_q    <= lmul[26:20];
      hr_q    <= '0;
      sr_q    <= '0;
      hbase_q <= hbase;
      hneg_q  <= hneg;
      grey_q  <= grey;
      sz_q    <= (sum == 9'd0) || (sum == 9'd510);
    end else if (cmd_i.step && cnt_q != 5'd0) begin
      hn_q <= {hn_q[14:0], 1'b0};
      sn_q <= {sn_q[14:0], 1'b0};
      if (hr_t >= 17'(hd_q)) begin
        hr_q <= hr_t - 17'(hd_q);
        hq_q <= {hq_q[14:0], 1'b1};
      end else begin
        hr_q <= hr_t;
        hq_q <= {hq_q[14:0], 1'b0};
      end
      if (sr_t >= 17'(sd_q)) begin
        sr_q <= sr_t - 17'(sd_q);
        sq_q <= {sq_q[14:0], 1'b1};
      end else begin
        sr_q <= sr_t;
        sq_q <= {sq_q[14:0], 1'b0};
      end
    end
  end

  assign status_o.div_done = cmd_i.step && (cnt_q == 5'd0);

  // Classification and frame bookkeeping, committed on result hand-off.
  logic [7:0]  hue, sat, light;
  logic        match, target, done;
  logic [10:0] w_c, h_c;
  logic [HW-1:0]  row_q, row_b;
  logic [WW-1:0]  col_q, col_b;
  logic [10:0] chits_q, chits_b, chits_n, best_q, best_b, best_n;
  logic [WW-1:0]  bidx_q, bidx_b, bidx_n;
  logic [20:0] fhits_q, fhits_b, fhits_n;
  logic        any_q, any_b, any_n;
  logic        row_end, col_end;

  always_comb begin
    if (grey_q) hue = 8'd0;
    else if (hneg_q) hue = hbase_q - hq_q[7:0];
    else hue = hbase_q + hq_q[7:0];
    sat   = sz_q ? 8'd0 : sq_q[7:0];
    light = {1'b0, lq_q};
    match = (hue > hue_low_q) && (hue < hue_high_q) &&
            (light > {1'b0, light_min_q}) && (sat > {1'b0, sat_min_q});
    target = match || (r_q == 8'hFF);

    w_c = (width_q == 11'd0) ? 11'd1 :
          ({21'd0, width_q} > 32'(MAX_WIDTH)) ? 11'(MAX_WIDTH) : width_q;
    h_c = (height_q == 11'd0) ? 11'd1 :
          ({21'd0, height_q} > 32'(MAX_HEIGHT)) ? 11'(MAX_HEIGHT) : height_q;

    row_b   = sof_q ? '0 : row_q;
    col_b   = sof_q ? '0 : col_q;
    chits_b = sof_q ? '0 : chits_q;
    best_b  = sof_q ? '0 : best_q;
    bidx_b  = sof_q ? '0 : bidx_q;
    fhits_b = sof_q ? '0 : fhits_q;
    any_b   = sof_q ? 1'b0 : any_q;

    chits_n = chits_b;
    fhits_n = fhits_b;
    any_n   = any_b;
    best_n  = best_b;
    bidx_n  = bidx_b;
    if (target) begin
      if (chits_b != 11'h7FF) chits_n = chits_b + 11'd1;
      if (fhits_b != 21'h1FFFFF) fhits_n = fhits_b + 21'd1;
      any_n = 1'b1;
      if (chits_n > best_b) begin
        best_n = chits_n;
        bidx_n = col_b;
      end
    end
    row_end = (32'(row_b) + 32'd1) >= 32'(h_c);
    col_end = (32'(col_b) + 32'd1) >= 32'(w_c);
    done    = row_end && col_end;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q   <= '0;
      col_q   <= '0;
      chits_q <= '0;
      best_q  <= '0;
      bidx_q  <= '0;
      fhits_q <= '0;
      any_q   <= 1'b0;
    end else if (cmd_i.commit) begin
      if (done) begin
        row_q   <= '0;
        col_q   <= '0;
        chits_q <= '0;
        best_q  <= '0;
        bidx_q  <= '0;
        fhits_q <= '0;
        any_q   <= 1'b0;
      end else begin
        best_q  <= best_n;
        bidx_q  <= bidx_n;
        fhits_q <= fhits_n;
        any_q   <= any_n;
        if (row_end) begin
          row_q   <= '0;
          chits_q <= '0;
          col_q   <= col_b + WW'(1);
        end else begin
          row_q   <= row_b + HW'(1);
          chits_q <= chits_n;
          col_q   <= col_b;
        end
      end
    end
  end

  assign out_red_o           = match ? 8'hFF : r_q;
  assign out_green_o         = match ? 8'h00 : g_q;
  assign out_blue_o          = match ? 8'h00 : b_q;
  assign is_target_o         = target;
  assign frame_done_o        = done;
  assign best_column_o       = done ? 10'(bidx_n) : 10'd0;
  assign best_column_count_o = done ? best_n : 11'd0;
  assign target_count_o      = done ? fhits_n : 21'd0;
  assign found_o             = done ? any_n : 1'b0;

`ifndef SYNTHESIS
  a_best_le_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(best_q) <= 32'(fhits_q)) else $error("best column above frame total");
  a_any_hits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    any_q == (fhits_q != 21'd0)) else $error("hit flag disagrees with count");
  a_cnt_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.prep |=> cnt_q == 5'(DivSteps)) else $error("divider not started");
`endif

endmodule

// File: hdl/hue_color_segment_column_peak_unit.sv
// Top level of the hue color segment column peak unit; uses hcs_ctrl, hcs_datapath, hcs_pkg.
// After an item is accepted, a setup state loads the operands of the bit-serial divider, which
// then forms the 16 quotient bits and takes one finishing step before the result is valid.
// The result is held until taken and the next item can be accepted the cycle after; no new
// item is taken while one is still in progress.
// Reset is asynchronous active low and restores register defaults and counts.
module hue_color_segment_column_peak_unit #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  red_i,
  input  logic [7:0]  green_i,
  input  logic [7:0]  blue_i,
  input  logic        start_of_frame_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  out_red_o,
  output logic [7:0]  out_green_o,
  output logic [7:0]  out_blue_o,
  output logic        is_target_o,
  output logic        frame_done_o,
  output logic [9:0]  best_column_o,
  output logic [10:0] best_column_count_o,
  output logic [20:0] target_count_o,
  output logic        found_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [10:0] cfg_data_i
);
  import hcs_pkg::*;

  cmd_t    cmd;
  status_t status;

  assign cfg_ready_o = 1'b1;

  hcs_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
    .status_i(status), .cmd_o(cmd)
  );

  hcs_datapath #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .status_o(status),
    .cfg_valid_i, .cfg_index_i, .cfg_data_i,
    .red_i, .green_i, .blue_i, .start_of_frame_i,
    .out_red_o, .out_green_o, .out_blue_o, .is_target_o, .frame_done_o,
    .best_column_o, .best_column_count_o, .target_count_o, .found_o
  );

endmodule

// File: tb/tb_top.sv
// Testbench for the hue color segment column peak unit.
// Drives pixels through valid/ready, predicts every result, and checks it.
// Depends on hcs_pkg and hue_color_segment_column_peak_unit.
module tb_top;
  import hcs_pkg::*;

  typedef struct packed {
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic        target;
    logic        done;
    logic [9:0]  best_col;
    logic [10:0] best_cnt;
    logic [20:0] total;
    logic        found;
  } pixel_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [7:0]  red_i = '0;
  logic [7:0]  green_i = '0;
  logic [7:0]  blue_i = '0;
  logic        start_of_frame_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [7:0]  out_red_o;
  logic [7:0]  out_green_o;
  logic [7:0]  out_blue_o;
  logic        is_target_o;
  logic        frame_done_o;
  logic [9:0]  best_column_o;
  logic [10:0] best_column_count_o;
  logic [20:0] target_count_o;
  logic        found_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = '0;
  logic [10:0] cfg_data_i = '0;

  hue_color_segment_column_peak_unit uut (.*);

  always #2 clk_i = ~clk_i;

  // Window and frame settings as seen by the predictor.
  int unsigned win_hue_low = 10, win_hue_high = 80, win_sat_min = 20, win_light_min = 20;
  int unsigned frm_width = 320, frm_height = 240;
  // Frame position and counts.
  int unsigned row_pos, col_pos, col_hits, peak_hits, peak_col, frame_hits;
  bit          any_target;

  pixel_result_t expected_pixels[$];
  int          errors = 0;
  int          pixels_checked = 0;
  int          frames_done = 0;
  bit          stall_mode = 0;

  function automatic int unsigned hue_of(int unsigned r, int unsigned g, int unsigned b,
                                         int unsigned mx, int unsigned mn);
    int unsigned d;
    int unsigned base;
    int unsigned p;
    int unsigned q;
    d = mx - mn;
    if (2 * d <= mx) return 0;
    if (r == mx) begin
      base = 42; p = g; q = b;
    end else if (g == mx) begin
      base = 126; p = b; q = r;
    end else begin
      base = 210; p = r; q = g;
    end
    if (p >= q) return base + (42 * (p - q)) / d;
    return base - (42 * (q - p)) / d;
  endfunction

  function automatic void clear_frame_counts();
    row_pos = 0; col_pos = 0; col_hits = 0; peak_hits = 0; peak_col = 0;
    frame_hits = 0; any_target = 0;
  endfunction

  function automatic pixel_result_t segment_pixel(logic [7:0] r, logic [7:0] g,
                                                  logic [7:0] b, logic sof);
    pixel_result_t res;
    int unsigned mx, mn, sum, den, hue, sat, light, w, h;
    bit match;
    if (sof) clear_frame_counts();
    mx = (r > g) ? r : g;
    mx = (mx > b) ? mx : b;
    mn = (r < g) ? r : g;
    mn = (mn < b) ? mn : b;
    sum = mx + mn;
    hue = hue_of(r, g, b, mx, mn);
    light = (100 * sum) / 510;
    den = (sum < 255) ? sum : 510 - sum;
    sat = (den != 0) ? (100 * (mx - mn)) / den : 0;
    match = hue > win_hue_low && hue < win_hue_high && light > win_light_min
            && sat > win_sat_min;
    res = '0;
    res.red = match ? 8'd255 : r;
    res.green = match ? 8'd0 : g;
    res.blue = match ? 8'd0 : b;
    res.target = match || r == 8'd255;
    if (res.target) begin
      if (col_hits < 2047) col_hits++;
      if (frame_hits < 2097151) frame_hits++;
      any_target = 1;
      if (col_hits > peak_hits) begin
        peak_hits = col_hits;
        peak_col = col_pos;
      end
    end
    w = (frm_width < 1) ? 1 : ((frm_width > 1024) ? 1024 : frm_width);
    h = (frm_height < 1) ? 1 : ((frm_height > 1024) ? 1024 : frm_height);
    if (row_pos + 1 >= h) begin
      row_pos = 0;
      col_hits = 0;
      if (col_pos + 1 >= w) res.done = 1;
      else col_pos++;
    end else begin
      row_pos++;
    end
    if (res.done) begin
      res.best_col = peak_col[9:0];
      res.best_cnt = peak_hits[10:0];
      res.total = frame_hits[20:0];
      res.found = any_target;
      clear_frame_counts();
    end
    return res;
  endfunction

  function automatic int gap_len();
    int sel;
    sel = $urandom_range(99);
    if (sel < 65) return 0;
    if (sel < 94) return $urandom_range(3, 1);
    return $urandom_range(30, 8);
  endfunction

  task automatic report_mismatch(string field, longint got, longint want);
    $display("mismatch on %s: got %0d, expected %0d (pixel %0d)", field, got, want,
             pixels_checked);
    errors++;
  endtask

  // Predicts every pixel the block accepts.
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o)
      expected_pixels.push_back(segment_pixel(red_i, green_i, blue_i, start_of_frame_i));
  end

  // Checks every result the block hands over.
  always @(posedge clk_i) begin
    pixel_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_pixels.size() == 0) begin
        report_mismatch("result with no pixel pending", 1, 0);
      end else begin
        want = expected_pixels.pop_front();
        if (out_red_o !== want.red) report_mismatch("out_red", out_red_o, want.red);
        if (out_green_o !== want.green) report_mismatch("out_green", out_green_o, want.green);
        if (out_blue_o !== want.blue) report_mismatch("out_blue", out_blue_o, want.blue);
        if (is_target_o !== want.target) report_mismatch("is_target", is_target_o, want.target);
        if (frame_done_o !== want.done) report_mismatch("frame_done", frame_done_o, want.done);
        if (best_column_o !== want.best_col)
          report_mismatch("best_column", best_column_o, want.best_col);
        if (best_column_count_o !== want.best_cnt)
          report_mismatch("best_column_count", best_column_count_o, want.best_cnt);
        if (target_count_o !== want.total)
          report_mismatch("target_count", target_count_o, want.total);
        if (found_o !== want.found) report_mismatch("found", found_o, want.found);
        if (want.done) frames_done++;
      end
      pixels_checked++;
    end
  end

  // Receiver back-pressure, with stretches where it never stalls.
  always @(posedge clk_i) begin
    if ($urandom_range(199) == 0) stall_mode <= ~stall_mode;
    out_ready_i <= stall_mode ? (gap_len() == 0) : 1'b1;
  end

  task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic sof);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    red_i <= r;
    green_i <= g;
    blue_i <= b;
    start_of_frame_i <= sof;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk_i);
    repeat (25) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [10:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      REG_HUE_LOW:      win_hue_low = val[7:0];
      REG_HUE_HIGH:     win_hue_high = val[7:0];
      REG_SAT_MIN:      win_sat_min = val[6:0];
      REG_LIGHT_MIN:    win_light_min = val[6:0];
      REG_FRAME_WIDTH:  frm_width = val;
      REG_FRAME_HEIGHT: frm_height = val;
      default: ;
    endcase
  endtask

  task automatic send_random_pixel(logic sof);
    logic [7:0] c[3];
    logic [7:0] t;
    int sel, k;
    sel = $urandom_range(99);
    c[0] = 8'($urandom); c[1] = 8'($urandom); c[2] = 8'($urandom);
    if (sel < 20) begin
      c[0] = 8'd255;
    end else if (sel < 32) begin
      c[1] = 8'(c[0] + $urandom_range(2)); c[2] = c[0];
    end else if (sel < 40) begin
      t = ($urandom_range(1) != 0) ? 8'd255 : 8'd0;
      c[0] = t; c[1] = t; c[2] = t;
    end else if (sel < 75) begin
      c[0] = 8'($urandom_range(255, 90));
      c[2] = 8'($urandom_range(c[0] / 3));
      c[1] = 8'($urandom_range(c[0], c[2]));
      k = $urandom_range(2);
      t = c[0]; c[0] = c[k]; c[k] = t;
    end
    send_pixel(c[0], c[1], c[2], sof);
  endtask

  task automatic test_directed();
    write_reg(REG_FRAME_WIDTH, 11'd3);
    write_reg(REG_FRAME_HEIGHT, 11'd2);
    // Column 0 holds one target, column 1 two and column 2 none.
    send_pixel(8'd255, 8'd0, 8'd0, 1'b1);
    send_pixel(8'd0, 8'd0, 8'd0, 1'b0);
    send_pixel(8'd255, 8'd255, 8'd255, 1'b0);
    send_pixel(8'd200, 8'd100, 8'd20, 1'b0);
    send_pixel(8'd128, 8'd128, 8'd128, 1'b0);
    send_pixel(8'd10, 8'd200, 8'd30, 1'b0);
    // A frame with no target at all.
    repeat (6) send_pixel(8'd90, 8'd90, 8'd91, 1'b0);
    // Every hue sector with both signs of the offset.
    send_pixel(8'd200, 8'd10, 8'd60, 1'b1);
    send_pixel(8'd60, 8'd200, 8'd10, 1'b0);
    send_pixel(8'd10, 8'd200, 8'd60, 1'b0);
    send_pixel(8'd10, 8'd60, 8'd200, 1'b0);
    send_pixel(8'd60, 8'd10, 8'd200, 1'b0);
    send_pixel(8'd254, 8'd253, 8'd1, 1'b0);
    send_pixel(8'd170, 8'd85, 8'd85, 1'b0);
    send_pixel(8'd1, 8'd0, 8'd0, 1'b0);
    send_pixel(8'd254, 8'd255, 8'd254, 1'b0);
    drain();
  endtask

  task automatic test_dimension_clamp();
    // A frame left partly done meets a smaller size, then clamped sizes.
    send_pixel(8'd255, 8'd1, 8'd2, 1'b1);
    send_pixel(8'd255, 8'd3, 8'd4, 1'b0);
    drain();
    write_reg(REG_FRAME_WIDTH, 11'd1);
    write_reg(REG_FRAME_HEIGHT, 11'd1);
    send_pixel(8'd7, 8'd8, 8'd9, 1'b0);
    drain();
    write_reg(REG_FRAME_WIDTH, 11'd2047);
    write_reg(REG_FRAME_HEIGHT, 11'd0);
    for (int i = 0; i < 1024; i++) send_random_pixel(i == 0);
    drain();
    write_reg(REG_FRAME_WIDTH, 11'd0);
    write_reg(REG_FRAME_HEIGHT, 11'd2);
    for (int i = 0; i < 6; i++) send_random_pixel(1'b0);
    drain();
  endtask

  task automatic test_random_frames();
    for (int ph = 0; ph < 14; ph++) begin
      write_reg(REG_HUE_LOW, (ph == 0) ? 11'd0 : (ph == 1) ? 11'd255 :
                11'($urandom_range(60)));
      write_reg(REG_HUE_HIGH, (ph == 0) ? 11'd255 : (ph == 1) ? 11'd0 :
                11'($urandom_range(252, 30)));
      write_reg(REG_SAT_MIN, (ph == 0) ? 11'd0 : (ph == 1) ? 11'd127 :
                11'($urandom_range(100)));
      write_reg(REG_LIGHT_MIN, (ph == 0) ? 11'd0 : (ph == 1) ? 11'd100 :
                11'($urandom_range(60)));
      write_reg(REG_FRAME_WIDTH, 11'($urandom_range(6, 1)));
      write_reg(REG_FRAME_HEIGHT, 11'($urandom_range(6, 1)));
      for (int i = 0; i < 50; i++) send_random_pixel($urandom_range(29) == 0);
      drain();
    end
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);
    test_directed();
    test_dimension_clamp();
    test_random_frames();
    $display("Covered %0d pixels and %0d completed frames across window and size settings.",
             pixels_checked, frames_done);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
